// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Implication form
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/pmst_pkg.sv -----
// ----------------------------------------------------------------------------
// pmst_pkg
// Constants and types for the dense-graph minimum spanning tree engine.
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;
    localparam int CFG_W        = 6;

    localparam int VIDX_W    = $clog2(MAX_VERTICES);
    localparam int VCNT_W    = VIDX_W + 1;
    localparam int KEY_W     = WEIGHT_BITS + 1;
    localparam int MAT_AW    = 2 * VIDX_W;
    localparam int MAT_DEPTH = 1 << MAT_AW;

    localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};

    // One vertex record in the state memory
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VIDX_W-1:0] parent;
        logic              in_tree;
    } pmst_entry_t;

    localparam int ENTRY_W = $bits(pmst_entry_t);

    // Sequencer states
    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_CLEAR    = 7'b0000010,
        S_PICK     = 7'b0000100,
        S_RELAX    = 7'b0001000,
        S_EMIT_RD  = 7'b0010000,
        S_EMIT_CAP = 7'b0100000,
        S_EMIT_OUT = 7'b1000000
    } pmst_state_t;

endpackage

// ----- rtl/core/pmst_ram.sv -----
// ----------------------------------------------------------------------------
// pmst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/prim_mst_dense.sv -----
// ----------------------------------------------------------------------------
// prim_mst_dense
// Prim minimum spanning tree over a stored dense adjacency matrix.
// ----------------------------------------------------------------------------
// Usage: write vertex_count (n) on the config port, then stream n*n matrix
// entries row-major, one per cycle (weight 0 = no edge). After the last entry
// the engine clears the n vertex records (when n is above 1), then runs n-1
// rounds, each a scan of the records for the minimum key and a relax pass
// that reads one matrix row and the records together; both passes go through
// the registered read port of the vertex record memory. Results for vertices
// 1..n-1 follow one at a time, each held until out_ready; no new request is
// taken until the last result leaves. Unreachable vertices report reached = 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prim_mst_dense (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [pmst_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pmst_pkg::WEIGHT_BITS-1:0] weight,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pmst_pkg::VIDX_W-1:0]      child,
    output logic [pmst_pkg::VIDX_W-1:0]      parent_vertex,
    output logic [pmst_pkg::WEIGHT_BITS-1:0] edge_weight,
    output logic                             reached,
    output logic                             last
);

    localparam int VW = pmst_pkg::VIDX_W;
    localparam int CW = pmst_pkg::VCNT_W;

    pmst_pkg::pmst_state_t state_reg, state_next;

    logic [pmst_pkg::CFG_W-1:0] vcount_reg;
    logic [CW-1:0]              n_act;
    logic [CW-1:0]              n_m1;

    logic [VW-1:0] row_reg, row_next, col_reg, col_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          p_vld_reg, p_vld_next;
    logic [VW-1:0] p_idx_reg, p_idx_next;
    logic [VW-1:0] u_reg, u_next;
    logic [CW-1:0] round_reg, round_next;
    logic [pmst_pkg::KEY_W-1:0] min_reg, min_next;
    logic          found_reg, found_next;
    logic [VW-1:0] e_idx_reg, e_idx_next;

    logic                             out_valid_reg;
    logic [VW-1:0]                    child_reg;
    logic [VW-1:0]                    parent_reg;
    logic [pmst_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic                             reached_reg;
    logic                             last_reg;

    // Memory ports
    logic                             mat_we;
    logic [pmst_pkg::MAT_AW-1:0]      mat_waddr, mat_raddr;
    logic [pmst_pkg::WEIGHT_BITS-1:0] mat_rdata;
    logic                             st_we;
    logic [VW-1:0]                    st_waddr, st_raddr;
    pmst_pkg::pmst_entry_t            st_wdata, st_rdata;

    logic issue;
    logic scan_last;
    logic take;
    logic in_acc;

    pmst_ram #(
        .WIDTH (pmst_pkg::WEIGHT_BITS),
        .DEPTH (pmst_pkg::MAT_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (weight),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    pmst_ram #(
        .WIDTH (pmst_pkg::ENTRY_W),
        .DEPTH (pmst_pkg::MAX_VERTICES)
    ) u_st_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Active vertex count, clamped to 1..MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = CW'(1);
        end
        else if (int'(vcount_reg) > pmst_pkg::MAX_VERTICES)
        begin
            n_act = CW'(pmst_pkg::MAX_VERTICES);
        end
        else
        begin
            n_act = CW'(vcount_reg);
        end
    end

    assign n_m1      = n_act - CW'(1);
    assign in_ready  = (state_reg == pmst_pkg::S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign issue     = (rd_idx_reg < n_act);
    assign scan_last = p_vld_reg && ({1'b0, p_idx_reg} == n_m1);
    assign take      = p_vld_reg && !st_rdata.in_tree &&
                       (!found_reg || (st_rdata.key < min_reg));

    // Matrix write and read addresses
    assign mat_we    = in_acc;
    assign mat_waddr = {row_reg, col_reg};
    assign mat_raddr = {u_reg, rd_idx_reg[VW-1:0]};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        rd_idx_next = rd_idx_reg;
        p_vld_next  = 1'b0;
        p_idx_next  = p_idx_reg;
        u_next      = u_reg;
        round_next  = round_reg;
        min_next    = min_reg;
        found_next  = found_reg;
        e_idx_next  = e_idx_reg;
        st_we       = 1'b0;
        st_waddr    = p_idx_reg;
        st_wdata    = st_rdata;
        st_raddr    = rd_idx_reg[VW-1:0];

        case (state_reg)
            pmst_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    if ({1'b0, col_reg} == n_m1)
                    begin
                        col_next = '0;
                        if ({1'b0, row_reg} == n_m1)
                        begin
                            row_next    = '0;
                            rd_idx_next = '0;
                            if (n_act != CW'(1))
                            begin
                                state_next = pmst_pkg::S_CLEAR;
                            end
                        end
                        else
                        begin
                            row_next = row_reg + VW'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + VW'(1);
                    end
                end
            end

            // Reset the active vertex records; vertex 0 is the root
            pmst_pkg::S_CLEAR:
            begin
                st_we            = 1'b1;
                st_waddr         = rd_idx_reg[VW-1:0];
                st_wdata.key     = (rd_idx_reg == '0) ? '0 : pmst_pkg::KEY_INF;
                st_wdata.parent  = '0;
                st_wdata.in_tree = 1'b0;
                if ({1'b0, rd_idx_reg[VW-1:0]} == n_m1)
                begin
                    rd_idx_next = '0;
                    round_next  = '0;
                    found_next  = 1'b0;
                    state_next  = pmst_pkg::S_PICK;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
            end

            // Scan for the lowest out-of-tree key
            pmst_pkg::S_PICK:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_idx_reg[VW-1:0];
                end
                if (take)
                begin
                    min_next   = st_rdata.key;
                    found_next = 1'b1;
                    u_next     = p_idx_reg;
                end
                if (scan_last)
                begin
                    rd_idx_next = '0;
                    p_vld_next  = 1'b0;
                    state_next  = pmst_pkg::S_RELAX;
                end
            end

            // Read row u with the records, write back relaxed keys and mark u in the tree
            pmst_pkg::S_RELAX:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_idx_reg[VW-1:0];
                end
                if (p_vld_reg)
                begin
                    st_we = 1'b1;
                    if (p_idx_reg == u_reg)
                    begin
                        st_wdata.in_tree = 1'b1;
                    end
                    else if ((mat_rdata != '0) && !st_rdata.in_tree &&
                             ({1'b0, mat_rdata} < st_rdata.key))
                    begin
                        st_wdata.key    = {1'b0, mat_rdata};
                        st_wdata.parent = u_reg;
                    end
                end
                if (scan_last)
                begin
                    rd_idx_next = '0;
                    p_vld_next  = 1'b0;
                    found_next  = 1'b0;
                    round_next  = round_reg + CW'(1);
                    if (round_reg + CW'(1) == n_m1)
                    begin
                        e_idx_next = VW'(1);
                        state_next = pmst_pkg::S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = pmst_pkg::S_PICK;
                    end
                end
            end

            pmst_pkg::S_EMIT_RD:
            begin
                st_raddr   = e_idx_reg;
                state_next = pmst_pkg::S_EMIT_CAP;
            end

            pmst_pkg::S_EMIT_CAP:
            begin
                state_next = pmst_pkg::S_EMIT_OUT;
            end

            pmst_pkg::S_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    if ({1'b0, e_idx_reg} == n_m1)
                    begin
                        state_next = pmst_pkg::S_LOAD;
                    end
                    else
                    begin
                        e_idx_next = e_idx_reg + VW'(1);
                        state_next = pmst_pkg::S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = pmst_pkg::S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmst_pkg::S_LOAD;
            vcount_reg    <= pmst_pkg::CFG_W'(pmst_pkg::MAX_VERTICES);
            row_reg       <= '0;
            col_reg       <= '0;
            rd_idx_reg    <= '0;
            p_vld_reg     <= 1'b0;
            round_reg     <= '0;
            found_reg     <= 1'b0;
            e_idx_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            p_vld_reg  <= p_vld_next;
            round_reg  <= round_next;
            found_reg  <= found_next;
            e_idx_reg  <= e_idx_next;
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
                row_reg    <= '0;
                col_reg    <= '0;
            end
            else
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (state_reg == pmst_pkg::S_EMIT_CAP)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        p_idx_reg <= p_idx_next;
        u_reg     <= u_next;
        min_reg   <= min_next;
        if (state_reg == pmst_pkg::S_EMIT_CAP)
        begin
            child_reg   <= e_idx_reg;
            reached_reg <= (st_rdata.key != pmst_pkg::KEY_INF);
            parent_reg  <= (st_rdata.key != pmst_pkg::KEY_INF) ? st_rdata.parent : '0;
            weight_reg  <= (st_rdata.key != pmst_pkg::KEY_INF) ?
                           st_rdata.key[pmst_pkg::WEIGHT_BITS-1:0] : '0;
            last_reg    <= ({1'b0, e_idx_reg} == n_m1);
        end
    end

    assign out_valid     = out_valid_reg;
    assign child         = child_reg;
    assign parent_vertex = parent_reg;
    assign edge_weight   = weight_reg;
    assign reached       = reached_reg;
    assign last          = last_reg;

    // Checks
    `ASSERT_CLK(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
    `ASSERT_CLK(a_child_nonroot, clk, rst_n, !out_valid || (child != '0))
    `ASSERT_IMPL(a_last_to_load, clk, rst_n, out_valid && out_ready && last, in_ready)
    `ASSERT_CLK(a_unreached_zero, clk, rst_n, !out_valid || reached || (edge_weight == '0))

endmodule
